>>> hdl/prle_pkg.sv
package prle_pkg;

  // Longest run or literal group, in bytes.
  localparam int MAX_GROUP = 128;
  localparam int IDX_W = $clog2(MAX_GROUP);

  // Group counter limits: a run of MAX_GROUP bytes, a literal of MAX_GROUP bytes.
  localparam logic signed [7:0] RUN_LIMIT = 8'(-(MAX_GROUP - 1));
  localparam logic signed [7:0] LIT_LIMIT = 8'(MAX_GROUP - 1);

  localparam logic [7:0] END_MARKER = 8'h80;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // What an accepted request does to the open group.
  typedef enum logic [2:0] {
    CLS_START,
    CLS_EXTEND_RUN,
    CLS_APPEND,
    CLS_FLUSH_RUN,
    CLS_FLUSH_LIT,
    CLS_SPLIT_LIT,
    CLS_END
  } cls_t;

  // Source of the byte sent to the packer.
  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_RUN,
    SEL_LIT,
    SEL_MARK
  } sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_HEAD,
    S_RUN,
    S_LIT,
    S_MARK
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic emit;
    sel_t sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic is_end;
    logic open;
    logic is_run;
    logic lit_done;
  } status_t;

endpackage

>>> hdl/prle_ctrl.sv
module prle_ctrl import prle_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  input  logic    byte_ok,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (status.cls) inside
          CLS_START, CLS_EXTEND_RUN, CLS_APPEND: begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
          CLS_FLUSH_RUN, CLS_FLUSH_LIT, CLS_SPLIT_LIT: begin
            state_next = S_HEAD;
          end
          CLS_END: begin
            state_next = status.open ? S_HEAD : S_MARK;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_HEAD: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_HEAD;
        if (byte_ok) begin
          state_next = status.is_run ? S_RUN : S_LIT;
        end
      end
      S_RUN: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_RUN;
        cmd.last = !status.is_end;
        if (byte_ok) begin
          if (status.is_end) begin
            state_next = S_MARK;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_LIT: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_LIT;
        cmd.last = status.lit_done && !status.is_end;
        if (byte_ok && status.lit_done) begin
          if (status.is_end) begin
            state_next = S_MARK;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_MARK: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_MARK;
        cmd.last = 1'b1;
        if (byte_ok) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // A literal flush leaves only after its last stored byte went out.
  a_lit_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIT && state_next != S_LIT) |-> (status.lit_done && byte_ok))
    else $error("literal flush ended early");
`endif

endmodule

>>> hdl/prle_dp.sv
module prle_dp import prle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  cmd_t                  cmd,
  input  logic                  byte_ok,
  output status_t               status,
  output logic [7:0]            emit_byte
);

  logic [7:0]       store [MAX_GROUP];
  logic [7:0]       mem_q;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             store_we;

  logic [7:0]       count;
  logic             open;
  logic [7:0]       prev;
  logic             in_op;
  logic [7:0]       in_byte;
  logic [IDX_W-1:0] lit_idx;

  logic             same;
  cls_t             cls;
  logic [7:0]       hdr;

  // Latched request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  always_comb begin
    same = (in_byte == prev);
    if (in_op) begin
      cls = CLS_END;
    end else if (!open) begin
      cls = CLS_START;
    end else if (same && $signed(count) <= 0) begin
      cls = ($signed(count) <= RUN_LIMIT) ? CLS_FLUSH_RUN : CLS_EXTEND_RUN;
    end else if (!same && $signed(count) >= 0) begin
      cls = ($signed(count) >= LIT_LIMIT) ? CLS_FLUSH_LIT : CLS_APPEND;
    end else if (!same) begin
      cls = CLS_FLUSH_RUN;
    end else begin
      cls = CLS_SPLIT_LIT;
    end
  end

  // A split literal drops its last byte, which then starts the run.
  assign hdr = (cls == CLS_SPLIT_LIT) ? count - 8'd1 : count;

  assign status.cls      = cls;
  assign status.is_end   = in_op;
  assign status.open     = open;
  assign status.is_run   = count[7];
  assign status.lit_done = (lit_idx == hdr[IDX_W-1:0]);

  always_comb begin
    unique case (cmd.sel)
      SEL_HEAD: emit_byte = hdr;
      SEL_RUN:  emit_byte = prev;
      SEL_LIT:  emit_byte = mem_q;
      SEL_MARK: emit_byte = END_MARKER;
      default:  emit_byte = END_MARKER;
    endcase
  end

  // Literal store: one write port, one registered read port.
  assign store_we = cmd.commit && (cls != CLS_END) && (cls != CLS_EXTEND_RUN);
  assign wr_addr  = (cls == CLS_APPEND) ? count[IDX_W-1:0] + IDX_W'(1) : '0;
  assign rd_addr  = (cmd.sel == SEL_LIT) ? (byte_ok ? lit_idx + IDX_W'(1) : lit_idx) : '0;

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[wr_addr] <= in_byte;
    end
    mem_q <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_idx <= '0;
    end else if (cmd.emit && cmd.sel == SEL_HEAD) begin
      lit_idx <= '0;
    end else if (cmd.emit && cmd.sel == SEL_LIT && byte_ok) begin
      lit_idx <= lit_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      open  <= 1'b0;
      prev  <= '0;
    end else if (cmd.commit) begin
      unique case (cls)
        CLS_END: begin
          count <= '0;
          open  <= 1'b0;
          prev  <= '0;
        end
        CLS_EXTEND_RUN: begin
          count <= count - 8'd1;
        end
        CLS_APPEND: begin
          count <= count + 8'd1;
          prev  <= in_byte;
        end
        CLS_SPLIT_LIT: begin
          count <= 8'hFF;
          open  <= 1'b1;
          prev  <= in_byte;
        end
        default: begin
          count <= '0;
          open  <= 1'b1;
          prev  <= in_byte;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_closed_zero: assert property (@(posedge clk) disable iff (rst)
    !open |-> (count == 8'd0))
    else $error("group counter nonzero with no open group");
`endif

endmodule

>>> hdl/prle_pack.sv
module prle_pack import prle_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   emit,
  input  logic                   last,
  input  logic [7:0]             emit_byte,
  output logic                   byte_ok,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast
);

  logic [7:0] acc [4];
  logic [1:0] acc_cnt;
  logic [7:0] word [4];
  logic [7:0] out_b [4];
  logic [2:0] out_cnt;
  logic       take;
  logic       complete;

  assign byte_ok  = !m_tvalid || m_tready;
  assign take     = emit && byte_ok;
  assign complete = last || (acc_cnt == 2'd3);

  // Bytes past the new one are zero.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < {1'b0, acc_cnt}) begin
        word[j] = acc[j];
      end else if (3'(j) == {1'b0, acc_cnt}) begin
        word[j] = emit_byte;
      end else begin
        word[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !complete) begin
      acc[acc_cnt] <= emit_byte;
    end
    if (take && complete) begin
      out_b   <= word;
      out_cnt <= {1'b0, acc_cnt} + 3'd1;
      m_tlast <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        acc_cnt <= complete ? 2'd0 : acc_cnt + 2'd1;
      end
      if (take && complete) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {5'd0, out_cnt, out_b[3], out_b[2], out_b[1], out_b[0]};

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_cnt != 3'd0 && out_cnt <= 3'd4))
    else $error("byte count out of range");

  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (out_cnt == 3'd4))
    else $error("short word before the end of a request");

  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_cnt != 3'd4) |-> (out_b[3] == 8'd0))
    else $error("unused byte lane not zero");
`endif

endmodule

>>> hdl/packbits_run_length_encoder.sv
// Channel  Dir  Signals                          Contents (lowest bit first)
// s        in   s_tvalid s_tready s_tdata s_tuser tdata: data_byte; tuser: op (1 = end)
// m        out  m_tvalid m_tready m_tdata m_tlast tdata: out_byte0..3, byte_count; tlast: final
//
// A data byte that opens, extends or appends to a group is taken in S_IDLE, then classified and
// its group state updated in S_DECIDE.
// A request that writes a group is classified, then emits its encoded bytes (header, run byte or
// each stored literal byte, end marker) one at a time while byte_ok is high.
// While a finished word waits with m_tready low, no further encoded byte is taken.
// Reset is synchronous and clears control state only; unwritten store entries are never read.
module packbits_run_length_encoder import prle_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
  input  logic                   s_tuser,   // [0] op: 0 = data byte, 1 = end of stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte0, [15:8] out_byte1,
                                            // [23:16] out_byte2, [31:24] out_byte3,
                                            // [34:32] byte_count, [39:35] zero
  output logic                   m_tlast    // last word of the request's encoded bytes
);

  cmd_t       cmd;
  status_t    status;
  logic       byte_ok;
  logic [7:0] emit_byte;

  // The controller sequences each request: classify, then header, body and marker bytes.
  prle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .byte_ok  (byte_ok),
    .cmd      (cmd)
  );

  // The datapath holds the open group and the literal store and picks each encoded byte.
  prle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .byte_ok   (byte_ok),
    .status    (status),
    .emit_byte (emit_byte)
  );

  // The packer gathers encoded bytes four to a word and marks the request's last word.
  prle_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .emit      (cmd.emit),
    .last      (cmd.last),
    .emit_byte (emit_byte),
    .byte_ok   (byte_ok),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
